### design/gbm_pkg.sv
// Shared types, constants and axis arithmetic for the greedy box merge block.
// Used by gbm_if, gbm_pair_unit and greedy_box_merge; depends on nothing else.
`default_nettype none

package gbm_pkg;

  // Store depth and the widths of its index and fill count
  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);

  // Field widths
  localparam int COORD_W  = 14;
  localparam int SCORE_W  = 16;
  localparam int LABEL_W  = 8;
  localparam int MARGIN_W = 8;
  localparam int EDGE_W   = 15;
  localparam int GROW_W   = 16;

  // Register reset values
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd10;
  localparam logic [EDGE_W-1:0]   IMAGE_RESET  = 15'd4096;
  localparam logic [COORD_W-1:0]  SIZE_MAX     = 14'h3FFF;

  // APB register map: register index sits in paddr[3:2]
  localparam int APB_ADDR_W = 4;
  localparam logic [1:0] REG_MARGIN       = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  // One stored box
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [SCORE_W-1:0] score;
    logic [LABEL_W-1:0] label;
  } box_t;

  // Configuration seen by the pair unit
  typedef struct packed {
    logic [MARGIN_W-1:0] margin;
    logic [EDGE_W-1:0]   image_width;
    logic [EDGE_W-1:0]   image_height;
  } cfg_t;

  // Grown interval along one axis: start and end, both non-negative
  typedef struct packed {
    logic [GROW_W-1:0] start;
    logic [GROW_W-1:0] stop;
  } grown_t;

  // Merged interval along one axis
  typedef struct packed {
    logic [COORD_W-1:0] start;
    logic [COORD_W-1:0] len;
  } span_t;

  // Grow by margin per side, shifted up if start is below 0; clamp end at edge
  function automatic grown_t grow_axis(logic [COORD_W-1:0] pos, logic [COORD_W-1:0] len,
                                       logic [MARGIN_W-1:0] m, logic [EDGE_W-1:0] edge_px);
    grown_t g;
    logic   above;
    above = ({2'b00, pos} >= {8'h00, m});
    if (above) begin
      g.start = {2'b00, pos} - {8'h00, m};
      g.stop  = {2'b00, pos} + {2'b00, len} + {8'h00, m};
    end else begin
      g.start = '0;
      g.stop  = {2'b00, len} + {7'h00, m, 1'b0};
    end
    if (g.stop > {1'b0, edge_px}) begin
      g.stop = {1'b0, edge_px};
    end
    return g;
  endfunction

  // Union of two intervals, clipped to edge and saturated to 0..SIZE_MAX
  function automatic span_t merge_axis(logic [COORD_W-1:0] a, logic [COORD_W-1:0] al,
                                       logic [COORD_W-1:0] b, logic [COORD_W-1:0] bl,
                                       logic [EDGE_W-1:0] edge_px);
    span_t              r;
    logic [COORD_W-1:0] s;
    logic [COORD_W:0]   e1;
    logic [COORD_W:0]   e2;
    logic [COORD_W:0]   far_end;
    logic [COORD_W:0]   len;
    logic [EDGE_W-1:0]  lim;
    s       = (a < b) ? a : b;
    e1      = {1'b0, a} + {1'b0, al};
    e2      = {1'b0, b} + {1'b0, bl};
    far_end = (e1 > e2) ? e1 : e2;
    len     = far_end - {1'b0, s};
    lim     = edge_px - {1'b0, s};
    r.start = s;
    if (edge_px < {1'b0, s}) begin
      r.len = '0;
    end else begin
      if (len > lim) begin
        len = lim;
      end
      r.len = (len > {1'b0, SIZE_MAX}) ? SIZE_MAX : len[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/gbm_if.sv
// Valid/ready channel interfaces for box beats in and surviving boxes out.
// Field widths come from gbm_pkg.
`default_nettype none

interface gbm_in_if;
  logic                           valid;
  logic                           ready;
  logic [gbm_pkg::COORD_W-1:0]    in_x;
  logic [gbm_pkg::COORD_W-1:0]    in_y;
  logic [gbm_pkg::COORD_W-1:0]    in_width;
  logic [gbm_pkg::COORD_W-1:0]    in_height;
  logic [gbm_pkg::SCORE_W-1:0]    in_score;
  logic [gbm_pkg::LABEL_W-1:0]    in_label;
  logic                           in_last;

  modport source (
    output valid, in_x, in_y, in_width, in_height, in_score, in_label, in_last,
    input  ready
  );
  modport sink (
    input  valid, in_x, in_y, in_width, in_height, in_score, in_label, in_last,
    output ready
  );
endinterface

interface gbm_out_if;
  logic                           valid;
  logic                           ready;
  logic [gbm_pkg::COORD_W-1:0]    out_x;
  logic [gbm_pkg::COORD_W-1:0]    out_y;
  logic [gbm_pkg::COORD_W-1:0]    out_width;
  logic [gbm_pkg::COORD_W-1:0]    out_height;
  logic [gbm_pkg::SCORE_W-1:0]    out_score;
  logic [gbm_pkg::LABEL_W-1:0]    out_label;
  logic                           out_last;

  modport source (
    output valid, out_x, out_y, out_width, out_height, out_score, out_label, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_width, out_height, out_score, out_label, out_last,
    output ready
  );
endinterface

`default_nettype wire

### design/gbm_pair_unit.sv
// Shared pair unit: grows two boxes (registered), then tests touch and forms the union.
// Depends on gbm_pkg.
`default_nettype none

module gbm_pair_unit (
  input  wire logic          clk_i,
  input  wire logic          grow_en_i,
  input  wire gbm_pkg::cfg_t cfg_i,
  input  wire gbm_pkg::box_t box_a_i,
  input  wire gbm_pkg::box_t box_b_i,
  output logic               touch_o,
  output gbm_pkg::box_t      merged_o
);

  gbm_pkg::grown_t ax_q, ay_q, bx_q, by_q;
  logic [gbm_pkg::GROW_W-1:0] lo_x, hi_x, lo_y, hi_y;
  gbm_pkg::span_t span_x, span_y;

  // Stage one: grown intervals of both boxes on both axes
  always_ff @(posedge clk_i) begin
    if (grow_en_i) begin
      ax_q <= gbm_pkg::grow_axis(box_a_i.x, box_a_i.w, cfg_i.margin, cfg_i.image_width);
      ay_q <= gbm_pkg::grow_axis(box_a_i.y, box_a_i.h, cfg_i.margin, cfg_i.image_height);
      bx_q <= gbm_pkg::grow_axis(box_b_i.x, box_b_i.w, cfg_i.margin, cfg_i.image_width);
      by_q <= gbm_pkg::grow_axis(box_b_i.y, box_b_i.h, cfg_i.margin, cfg_i.image_height);
    end
  end

  // Stage two: inclusive overlap test on the grown rectangles
  always_comb begin
    lo_x    = (ax_q.start > bx_q.start) ? ax_q.start : bx_q.start;
    hi_x    = (ax_q.stop < bx_q.stop) ? ax_q.stop : bx_q.stop;
    lo_y    = (ay_q.start > by_q.start) ? ay_q.start : by_q.start;
    hi_y    = (ay_q.stop < by_q.stop) ? ay_q.stop : by_q.stop;
    touch_o = (hi_x >= lo_x) && (hi_y >= lo_y);
  end

  // Union of the ungrown boxes, clipped; keep the larger score and box a's label
  always_comb begin
    span_x = gbm_pkg::merge_axis(box_a_i.x, box_a_i.w, box_b_i.x, box_b_i.w,
                                 cfg_i.image_width);
    span_y = gbm_pkg::merge_axis(box_a_i.y, box_a_i.h, box_b_i.y, box_b_i.h,
                                 cfg_i.image_height);
    merged_o.x     = span_x.start;
    merged_o.w     = span_x.len;
    merged_o.y     = span_y.start;
    merged_o.h     = span_y.len;
    merged_o.score = (box_b_i.score > box_a_i.score) ? box_b_i.score : box_a_i.score;
    merged_o.label = box_a_i.label;
  end

endmodule

`default_nettype wire

### design/greedy_box_merge.sv
// Greedy bounding-box merge. Box beats are loaded while idle; the last beat starts
// the merge pass: each live box i is read and held, then every live later box is read,
// grown with box i and tested; a touching box is merged into box i and dropped.
// Emit skips dropped entries and holds each survivor until the output accepts it.
// Reset (async, active low) clears control, fill count and live bits and loads the
// register defaults; the box store is not cleared and needs no clearing pass.
`default_nettype none

module greedy_box_merge (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [gbm_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready,
  gbm_in_if.sink                                  box_i,
  gbm_out_if.source                               box_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_I_CHK  = 4'd1;
  localparam logic [3:0] ST_I_LD   = 4'd2;
  localparam logic [3:0] ST_J_RD   = 4'd3;
  localparam logic [3:0] ST_J_GROW = 4'd4;
  localparam logic [3:0] ST_J_TEST = 4'd5;
  localparam logic [3:0] ST_E_CHK  = 4'd6;
  localparam logic [3:0] ST_E_RD   = 4'd7;
  localparam logic [3:0] ST_E_WAIT = 4'd8;

  localparam logic [gbm_pkg::CNT_W-1:0] CNT_FULL = gbm_pkg::CNT_W'(gbm_pkg::MAX_BOXES);
  localparam logic [gbm_pkg::CNT_W-1:0] CNT_ONE  = gbm_pkg::CNT_W'(1);

  logic [3:0]                         state_q, state_d;
  logic [gbm_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic [gbm_pkg::CNT_W-1:0]          i_q, i_d;
  logic [gbm_pkg::CNT_W-1:0]          j_q, j_d;
  logic [gbm_pkg::MAX_BOXES-1:0]      alive_q, alive_d;
  logic                               out_valid_q, out_valid_d;
  gbm_pkg::box_t                      out_q;
  logic                               out_last_q;
  gbm_pkg::box_t                      cur_q, cur_d;
  logic                               cur_en;
  logic                               out_en;
  logic                               out_last_d;
  logic [gbm_pkg::MAX_BOXES-1:0]      tail;

  logic [gbm_pkg::MARGIN_W-1:0]       margin_q;
  logic [gbm_pkg::EDGE_W-1:0]         image_width_q;
  logic [gbm_pkg::EDGE_W-1:0]         image_height_q;
  gbm_pkg::cfg_t                      cfg;

  gbm_pkg::box_t                      mem [gbm_pkg::MAX_BOXES];
  gbm_pkg::box_t                      rd_q;
  gbm_pkg::box_t                      wr_data;
  gbm_pkg::box_t                      in_box;
  logic                               wr_en, rd_en;
  logic [gbm_pkg::IDX_W-1:0]          wr_addr, rd_addr;

  logic                               grow_en;
  logic                               touch;
  gbm_pkg::box_t                      merged;
  logic                               in_beat, out_beat, cfg_wr;

  // Configuration registers over APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q       <= gbm_pkg::MARGIN_RESET;
      image_width_q  <= gbm_pkg::IMAGE_RESET;
      image_height_q <= gbm_pkg::IMAGE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        gbm_pkg::REG_MARGIN:       margin_q       <= pwdata[gbm_pkg::MARGIN_W-1:0];
        gbm_pkg::REG_IMAGE_WIDTH:  image_width_q  <= pwdata[gbm_pkg::EDGE_W-1:0];
        gbm_pkg::REG_IMAGE_HEIGHT: image_height_q <= pwdata[gbm_pkg::EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gbm_pkg::REG_MARGIN:       prdata = {24'h0, margin_q};
      gbm_pkg::REG_IMAGE_WIDTH:  prdata = {17'h0, image_width_q};
      gbm_pkg::REG_IMAGE_HEIGHT: prdata = {17'h0, image_height_q};
      default:                   prdata = '0;
    endcase
  end

  assign cfg.margin       = margin_q;
  assign cfg.image_width  = image_width_q;
  assign cfg.image_height = image_height_q;

  // Channel handshakes
  assign box_i.ready = (state_q == ST_IDLE);
  assign in_beat     = box_i.valid && box_i.ready;
  assign out_beat    = out_valid_q && box_o.ready;

  assign in_box.x     = box_i.in_x;
  assign in_box.y     = box_i.in_y;
  assign in_box.w     = box_i.in_width;
  assign in_box.h     = box_i.in_height;
  assign in_box.score = box_i.in_score;
  assign in_box.label = box_i.in_label;

  // Shared pair unit: box i held in cur_q, box j from the store read register
  gbm_pair_unit u_pair (
    .clk_i     (clk_i),
    .grow_en_i (grow_en),
    .cfg_i     (cfg),
    .box_a_i   (cur_q),
    .box_b_i   (rd_q),
    .touch_o   (touch),
    .merged_o  (merged)
  );

  // Final flag: no live entry above the one being emitted
  assign tail       = alive_q >> i_q[gbm_pkg::IDX_W-1:0];
  assign out_last_d = ~|tail[gbm_pkg::MAX_BOXES-1:1];

  // Sequencer: load, merge pass, emit
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    alive_d     = alive_q;
    out_valid_d = out_valid_q;
    cur_d       = cur_q;
    cur_en      = 1'b0;
    out_en      = 1'b0;
    grow_en     = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cnt_q[gbm_pkg::IDX_W-1:0];
    wr_data     = in_box;
    rd_en       = 1'b0;
    rd_addr     = i_q[gbm_pkg::IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          // store the beat unless full; the last beat still starts the merge
          if (cnt_q < CNT_FULL) begin
            wr_en                                  = 1'b1;
            alive_d[cnt_q[gbm_pkg::IDX_W-1:0]]     = 1'b1;
            cnt_d                                  = cnt_q + CNT_ONE;
          end
          if (box_i.in_last) begin
            i_d     = '0;
            state_d = ST_I_CHK;
          end
        end
      end
      ST_I_CHK: begin
        if (i_q >= cnt_q) begin
          i_d     = '0;
          state_d = ST_E_CHK;
        end else if (!alive_q[i_q[gbm_pkg::IDX_W-1:0]]) begin
          i_d = i_q + CNT_ONE;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_I_LD;
        end
      end
      ST_I_LD: begin
        cur_d   = rd_q;
        cur_en  = 1'b1;
        j_d     = i_q + CNT_ONE;
        state_d = ST_J_RD;
      end
      ST_J_RD: begin
        if (j_q >= cnt_q) begin
          // write box i back and move to the next i
          wr_en   = 1'b1;
          wr_addr = i_q[gbm_pkg::IDX_W-1:0];
          wr_data = cur_q;
          i_d     = i_q + CNT_ONE;
          state_d = ST_I_CHK;
        end else if (!alive_q[j_q[gbm_pkg::IDX_W-1:0]]) begin
          j_d = j_q + CNT_ONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = j_q[gbm_pkg::IDX_W-1:0];
          state_d = ST_J_GROW;
        end
      end
      ST_J_GROW: begin
        grow_en = 1'b1;
        state_d = ST_J_TEST;
      end
      ST_J_TEST: begin
        if (touch) begin
          cur_d                              = merged;
          cur_en                             = 1'b1;
          alive_d[j_q[gbm_pkg::IDX_W-1:0]]   = 1'b0;
        end
        j_d     = j_q + CNT_ONE;
        state_d = ST_J_RD;
      end
      ST_E_CHK: begin
        if (i_q >= cnt_q) begin
          // empty the store for the next set
          alive_d = '0;
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else if (!alive_q[i_q[gbm_pkg::IDX_W-1:0]]) begin
          i_d = i_q + CNT_ONE;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_E_RD;
        end
      end
      ST_E_RD: begin
        out_en      = 1'b1;
        out_valid_d = 1'b1;
        state_d     = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        if (out_beat) begin
          out_valid_d = 1'b0;
          i_d         = i_q + CNT_ONE;
          state_d     = ST_E_CHK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      alive_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      alive_q     <= alive_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: working box i and output beat
  always_ff @(posedge clk_i) begin
    if (cur_en) begin
      cur_q <= cur_d;
    end
    if (out_en) begin
      out_q      <= rd_q;
      out_last_q <= out_last_d;
    end
  end

  // Box store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Drive the output channel
  assign box_o.valid      = out_valid_q;
  assign box_o.out_x      = out_q.x;
  assign box_o.out_y      = out_q.y;
  assign box_o.out_width  = out_q.w;
  assign box_o.out_height = out_q.h;
  assign box_o.out_score  = out_q.score;
  assign box_o.out_label  = out_q.label;
  assign box_o.out_last   = out_last_q;

endmodule

`default_nettype wire
